// ----- rtl/vn_pkg.sv -----
// ----------------------------------------------------------------------------
// vn_pkg
// Shared widths and transaction types of the vector normalizer.
// ----------------------------------------------------------------------------
package vn_pkg;

   localparam int COMP_WIDTH     = 16;
   localparam int UNIT_FRAC_BITS = 14;
   localparam int LEN2_WIDTH     = 2 * COMP_WIDTH;
   localparam int LEN_WIDTH      = COMP_WIDTH;
   localparam int UNIT_WIDTH     = 16;
   // quotient magnitude never exceeds 2^UNIT_FRAC_BITS
   localparam int QUOT_WIDTH     = UNIT_FRAC_BITS + 1;
   localparam int DIVD_WIDTH     = COMP_WIDTH + UNIT_FRAC_BITS;
   localparam int SQRT_REM_WIDTH = LEN_WIDTH + 2;

   typedef struct packed {
      logic signed [COMP_WIDTH-1:0] comp_x;
      logic signed [COMP_WIDTH-1:0] comp_y;
      logic signed [COMP_WIDTH-1:0] comp_z;
   } req_type;

   typedef struct packed {
      logic [LEN2_WIDTH-1:0]        length_squared;
      logic [LEN_WIDTH-1:0]         length;
      logic signed [UNIT_WIDTH-1:0] unit_x;
      logic signed [UNIT_WIDTH-1:0] unit_y;
      logic signed [UNIT_WIDTH-1:0] unit_z;
      logic                         zero_vector;
   } rsp_type;

endpackage

// ----- rtl/vn_delay.sv -----
// ----------------------------------------------------------------------------
// vn_delay
// Enabled shift line that carries side data alongside the pipeline.
// ----------------------------------------------------------------------------
module vn_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] din,
   output logic [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= din;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign dout = tap_ff[DEPTH-1];
endmodule

// ----- rtl/vn_sqrt.sv -----
// ----------------------------------------------------------------------------
// vn_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vn_sqrt (
   input  logic                          clock,
   input  logic                          en,
   input  logic [vn_pkg::LEN2_WIDTH-1:0] radicand,
   output logic [vn_pkg::LEN_WIDTH-1:0]  root
);
   import vn_pkg::*;

   localparam int STAGES = LEN_WIDTH;

   logic [LEN2_WIDTH-1:0]     rad_ff  [STAGES];
   logic [SQRT_REM_WIDTH-1:0] rem_ff  [STAGES];
   logic [LEN_WIDTH-1:0]      root_ff [STAGES];

   logic [LEN2_WIDTH-1:0]     rad_in  [STAGES];
   logic [SQRT_REM_WIDTH-1:0] rem_in  [STAGES];
   logic [LEN_WIDTH-1:0]      root_in [STAGES];

   always_comb begin
      logic [LEN2_WIDTH-1:0]       rad_prev;
      logic [SQRT_REM_WIDTH-1:0]   rem_prev;
      logic [LEN_WIDTH-1:0]        root_prev;
      logic [SQRT_REM_WIDTH+1:0]   rem_sh;
      logic [SQRT_REM_WIDTH+1:0]   trial;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            rad_prev  = radicand;
            rem_prev  = '0;
            root_prev = '0;
         end else begin
            rad_prev  = rad_ff[k-1];
            rem_prev  = rem_ff[k-1];
            root_prev = root_ff[k-1];
         end
         // bring down the next two radicand bits
         rem_sh = {rem_prev, rad_prev[LEN2_WIDTH-1 -: 2]};
         trial  = {2'b00, root_prev, 2'b01};
         rad_in[k] = {rad_prev[LEN2_WIDTH-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in[k]  = SQRT_REM_WIDTH'(rem_sh - trial);
            root_in[k] = {root_prev[LEN_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[k]  = SQRT_REM_WIDTH'(rem_sh);
            root_in[k] = {root_prev[LEN_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            rad_ff[k]  <= rad_in[k];
            rem_ff[k]  <= rem_in[k];
            root_ff[k] <= root_in[k];
         end
      end
   end

   assign root = root_ff[STAGES-1];
endmodule

// ----- rtl/vn_div_lane.sv -----
// ----------------------------------------------------------------------------
// vn_div_lane
// One divide lane: (mag << frac) / len, restoring, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vn_div_lane (
   input  logic                          clock,
   input  logic                          en,
   input  logic [vn_pkg::COMP_WIDTH-1:0] mag,
   input  logic [vn_pkg::LEN_WIDTH-1:0]  divisor,
   output logic [vn_pkg::QUOT_WIDTH-1:0] quot
);
   import vn_pkg::*;

   localparam int STAGES = QUOT_WIDTH;

   logic [LEN_WIDTH-1:0]  rem_ff [STAGES];
   logic [QUOT_WIDTH-1:0] low_ff [STAGES];
   logic [QUOT_WIDTH-1:0] q_ff   [STAGES];
   logic [LEN_WIDTH-1:0]  dvs_ff [STAGES];

   logic [LEN_WIDTH-1:0]  rem_in [STAGES];
   logic [QUOT_WIDTH-1:0] low_in [STAGES];
   logic [QUOT_WIDTH-1:0] q_in   [STAGES];
   logic [LEN_WIDTH-1:0]  dvs_in [STAGES];

   logic [DIVD_WIDTH-1:0] dividend;
   assign dividend = {mag, {UNIT_FRAC_BITS{1'b0}}};

   always_comb begin
      logic [LEN_WIDTH-1:0]  rem_prev;
      logic [QUOT_WIDTH-1:0] low_prev;
      logic [QUOT_WIDTH-1:0] q_prev;
      logic [LEN_WIDTH-1:0]  dvs_prev;
      logic [LEN_WIDTH:0]    r;
      for (int k = 0; k < STAGES; k++) begin
         if (k == 0) begin
            // quotient fits QUOT_WIDTH bits, so the top part is below len
            rem_prev = LEN_WIDTH'(dividend[DIVD_WIDTH-1:QUOT_WIDTH]);
            low_prev = dividend[QUOT_WIDTH-1:0];
            q_prev   = '0;
            dvs_prev = divisor;
         end else begin
            rem_prev = rem_ff[k-1];
            low_prev = low_ff[k-1];
            q_prev   = q_ff[k-1];
            dvs_prev = dvs_ff[k-1];
         end
         r = {rem_prev, low_prev[QUOT_WIDTH-1]};
         low_in[k] = {low_prev[QUOT_WIDTH-2:0], 1'b0};
         dvs_in[k] = dvs_prev;
         if (r >= {1'b0, dvs_prev}) begin
            rem_in[k] = LEN_WIDTH'(r - {1'b0, dvs_prev});
            q_in[k]   = {q_prev[QUOT_WIDTH-2:0], 1'b1};
         end else begin
            rem_in[k] = LEN_WIDTH'(r);
            q_in[k]   = {q_prev[QUOT_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            q_ff[k]   <= q_in[k];
            dvs_ff[k] <= dvs_in[k];
         end
      end
   end

   assign quot = q_ff[STAGES-1];
endmodule

// ----- rtl/vector3_normalizer_top.sv -----
// ----------------------------------------------------------------------------
// vector3_normalizer_top
// Squared length, floor-sqrt length and Q1.14 unit vector of a Q8.8 vector.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one transaction carries comp_x/y/z (signed Q8.8).
//  - rsp channel: one transaction per request with length_squared (Q16.16),
//    length (Q8.8), unit_x/y/z (Q1.14, truncated toward zero), zero_vector.
//  - Pipeline: the accept edge loads the input regs; then come squares,
//    sum, 16 sqrt stages, 15 divide stages, merge and output register.
//  - Throughput: one transaction per cycle while the skid register is
//    empty. The sqrt and the three divide lanes are fully pipelined,
//    one result bit per stage.
//  - Stall: the pipeline advances while the skid register is empty. When
//    the output register is held by rsp_ready low, the next result parks in
//    the skid register and req_ready drops until it drains.
//  - req_ready is registered state only; no path from rsp_ready to req_ready.
//  - Reset clears all valid bits; data registers are not reset.
//  - Zero vector: unit fields are zero and zero_vector is set.
// ----------------------------------------------------------------------------
module vector3_normalizer_top (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  vn_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output vn_pkg::rsp_type rsp_data
);
   import vn_pkg::*;

   // stage numbers of the valid line
   localparam int V_SUM  = 2;
   localparam int V_SQRT = V_SUM + LEN_WIDTH;
   localparam int V_DIV  = V_SQRT + QUOT_WIDTH;
   localparam int V_LAST = V_DIV + 1;

   logic pipe_en;
   logic [V_LAST:0] vld_ff;

   logic skid_vld_ff;
   logic out_vld_ff;
   rsp_type out_ff;
   rsp_type skid_ff;

   // global advance: only blocked by a parked result
   assign pipe_en   = !skid_vld_ff;
   assign req_ready = pipe_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (pipe_en) begin
         vld_ff <= {vld_ff[V_LAST-1:0], req_valid};
      end
   end

   // stage 0: magnitude and sign of each component
   logic [COMP_WIDTH-1:0] mag_ff [3];
   logic [2:0]            neg_ff;
   logic [COMP_WIDTH-1:0] comp   [3];

   assign comp[0] = req_data.comp_x;
   assign comp[1] = req_data.comp_y;
   assign comp[2] = req_data.comp_z;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= comp[i][COMP_WIDTH-1];
            mag_ff[i] <= comp[i][COMP_WIDTH-1] ? COMP_WIDTH'(-comp[i]) : comp[i];
         end
      end
   end

   // stage 1: squares, stage 2: sum (bounded by 3 * 2^30, fits 32 bits)
   logic [LEN2_WIDTH-1:0] sq_ff [3];
   logic [LEN2_WIDTH-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= mag_ff[i] * mag_ff[i];
         end
         sum_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
      end
   end

   logic [LEN_WIDTH-1:0] root;

   vn_sqrt u_sqrt (
      .clock    (clock),
      .en       (pipe_en),
      .radicand (sum_ff),
      .root     (root)
   );

   // side data lined up with the sqrt result (mag_d) and the divide result
   logic [3*COMP_WIDTH-1:0] mag_d;
   logic [2:0]              neg_d;
   logic [LEN2_WIDTH-1:0]   sum_d;
   logic [LEN_WIDTH-1:0]    root_d;

   vn_delay #(.WIDTH(3*COMP_WIDTH), .DEPTH(V_SQRT)) u_mag_dly (
      .clock (clock), .en (pipe_en),
      .din   ({mag_ff[2], mag_ff[1], mag_ff[0]}), .dout (mag_d)
   );

   vn_delay #(.WIDTH(3), .DEPTH(V_DIV)) u_neg_dly (
      .clock (clock), .en (pipe_en), .din (neg_ff), .dout (neg_d)
   );

   vn_delay #(.WIDTH(LEN2_WIDTH), .DEPTH(V_DIV - V_SUM)) u_sum_dly (
      .clock (clock), .en (pipe_en), .din (sum_ff), .dout (sum_d)
   );

   vn_delay #(.WIDTH(LEN_WIDTH), .DEPTH(QUOT_WIDTH)) u_root_dly (
      .clock (clock), .en (pipe_en), .din (root), .dout (root_d)
   );

   // three divide lanes, one per component
   logic [QUOT_WIDTH-1:0] quot [3];

   for (genvar g = 0; g < 3; g++) begin : g_lane
      vn_div_lane u_lane (
         .clock   (clock),
         .en      (pipe_en),
         .mag     (mag_d[g*COMP_WIDTH +: COMP_WIDTH]),
         .divisor (root),
         .quot    (quot[g])
      );
   end

   // merge: apply signs, force zero vector
   rsp_type res_ff;
   logic    is_zero;
   logic [UNIT_WIDTH-1:0] unit [3];

   assign is_zero = (root_d == '0);

   always_comb begin
      logic [UNIT_WIDTH-1:0] q_ext;
      for (int i = 0; i < 3; i++) begin
         q_ext   = UNIT_WIDTH'(quot[i]);
         unit[i] = is_zero ? '0 : (neg_d[i] ? UNIT_WIDTH'(-q_ext) : q_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         res_ff.length_squared <= sum_d;
         res_ff.length         <= root_d;
         res_ff.unit_x         <= unit[0];
         res_ff.unit_y         <= unit[1];
         res_ff.unit_z         <= unit[2];
         res_ff.zero_vector    <= is_zero;
      end
   end

   // output register plus skid register
   logic push;
   assign push = pipe_en && vld_ff[V_LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            out_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= push;
         end
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || rsp_ready) begin
         out_ff <= skid_vld_ff ? skid_ff : res_ff;
      end else if (push) begin
         skid_ff <= res_ff;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

   // a parked result always sits behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid register full while output register empty");

   // zero flag goes with all-zero unit fields
   a_zero_units: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_vector) |->
         (rsp_data.unit_x == '0 && rsp_data.unit_y == '0 && rsp_data.unit_z == '0))
      else $error("zero vector with nonzero unit component");

   // length is a floor square root of length_squared
   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({16'd0, rsp_data.length} * {16'd0, rsp_data.length}
                     <= rsp_data.length_squared))
      else $error("length exceeds square root of length_squared");

endmodule
